FILE: src/utf8_name_validator_top_macros.svh
// assertion macros shared by the checker of the utf8 name validator
`ifndef UTF8_NAME_VALIDATOR_TOP_MACROS_SVH
`define UTF8_NAME_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, quiet during reset
`define UNV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 name validator check failed");

// next-cycle implication, sampled on the rising clock edge, quiet during reset
`define UNV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 name validator check failed");

`endif

FILE: src/utf8nv_pkg.sv
// types and constants shared by the utf8 name validator modules
`timescale 1ns / 1ps

package utf8nv_pkg;

  // one input word as it is held in the input register
  typedef struct packed {
    logic [7:0] name_byte;
    logic       last;
  } item_t;

  // byte classes
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] DEL_CHAR   = 8'h7f;
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_CODE = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_CODE = 8'he0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_CODE = 8'hf0;
  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // code point limits
  localparam logic [20:0] MIN_CP2   = 21'h00080;
  localparam logic [20:0] MIN_CP3   = 21'h00800;
  localparam logic [20:0] MIN_CP4   = 21'h10000;
  localparam logic [20:0] MAX_CP    = 21'h10ffff;
  localparam logic [20:0] SURR_LOW  = 21'h0d800;
  localparam logic [20:0] SURR_HIGH = 21'h0dfff;

endpackage

FILE: src/utf8nv_in_reg.sv
// input register: holds one word until the checking stage takes it
`timescale 1ns / 1ps

module utf8nv_in_reg
  import utf8nv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] name_byte,
  input  logic       last,
  input  logic       consume,
  output logic       s1_valid,
  output item_t      s1_item
);

  // hold back the sender only while the held word cannot move on
  assign in_stall = s1_valid && !consume;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item.name_byte <= name_byte;
      s1_item.last      <= last;
    end
  end

endmodule

FILE: src/utf8nv_core.sv
// decode stage: per-byte utf8 and length checks, and the verdict register
`timescale 1ns / 1ps

module utf8nv_core
  import utf8nv_pkg::*;
#(
  parameter int MAX_NAME = 33
)
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s1_valid,
  input  item_t s1_item,
  input  logic  out_stall,
  output logic  consume,
  output logic  out_valid,
  output logic  printable
);

  localparam int LEN_W = $clog2(MAX_NAME + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME);

  logic [1:0]       bytes_pending, bytes_pending_next;
  logic [1:0]       sequence_length, sequence_length_next;
  logic [20:0]      code_point, code_point_next;
  logic [LEN_W-1:0] name_length, name_length_next;
  logic             rejected, rejected_next;
  logic             terminated, terminated_next;
  logic [20:0]      cp_shift;
  logic [7:0]       b;
  logic             verdict;

  assign b        = s1_item.name_byte;
  assign cp_shift = {code_point[14:0], b[5:0]};

  // a word with no verdict always moves; a last word needs a free result slot
  assign consume = s1_valid && (!s1_item.last || !out_valid || !out_stall);

  // next state for one byte
  always_comb begin
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    code_point_next      = code_point;
    name_length_next     = name_length;
    rejected_next        = rejected;
    terminated_next      = terminated;
    if (!terminated) begin
      if (b == 8'h00) begin
        terminated_next = 1'b1;
      end else begin
        // saturating length count
        if (name_length != LEN_MAX) begin
          name_length_next = name_length + 1'b1;
        end
        if (name_length_next == LEN_MAX) begin
          rejected_next = 1'b1;
        end
        if (bytes_pending == 2'd0) begin
          // lead byte
          if (b < CTRL_LIMIT || b == DEL_CHAR) begin
            rejected_next = 1'b1;
          end else if (!b[7]) begin
            rejected_next = rejected_next;
          end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            sequence_length_next = 2'd1;
            bytes_pending_next   = 2'd1;
            code_point_next      = {16'd0, b[4:0]};
          end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            sequence_length_next = 2'd2;
            bytes_pending_next   = 2'd2;
            code_point_next      = {17'd0, b[3:0]};
          end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            sequence_length_next = 2'd3;
            bytes_pending_next   = 2'd3;
            code_point_next      = {18'd0, b[2:0]};
          end else begin
            rejected_next = 1'b1;
          end
        end else begin
          // continuation byte
          if ((b & CONT_MASK) != CONT_CODE) begin
            rejected_next      = 1'b1;
            bytes_pending_next = 2'd0;
          end else begin
            code_point_next    = cp_shift;
            bytes_pending_next = bytes_pending - 2'd1;
            if (bytes_pending_next == 2'd0) begin
              // overlong, surrogate and range checks on the finished code point
              if ((sequence_length == 2'd1 && cp_shift < MIN_CP2) ||
                  (sequence_length == 2'd2 && cp_shift < MIN_CP3) ||
                  (sequence_length == 2'd3 && cp_shift < MIN_CP4) ||
                  cp_shift > MAX_CP ||
                  (cp_shift >= SURR_LOW && cp_shift <= SURR_HIGH)) begin
                rejected_next = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign verdict = !rejected_next && (name_length_next != '0) && (bytes_pending_next == 2'd0);

  // name state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= 2'd0;
      sequence_length <= 2'd0;
      code_point      <= '0;
      name_length     <= '0;
      rejected        <= 1'b0;
      terminated      <= 1'b0;
    end else if (consume) begin
      if (s1_item.last) begin
        bytes_pending   <= 2'd0;
        sequence_length <= 2'd0;
        code_point      <= '0;
        name_length     <= '0;
        rejected        <= 1'b0;
        terminated      <= 1'b0;
      end else begin
        bytes_pending   <= bytes_pending_next;
        sequence_length <= sequence_length_next;
        code_point      <= code_point_next;
        name_length     <= name_length_next;
        rejected        <= rejected_next;
        terminated      <= terminated_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && s1_item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && s1_item.last) begin
      printable <= verdict;
    end
  end

endmodule

FILE: src/utf8_name_validator_top.sv
// top level of the utf8 name validator
//
// A name enters one byte per word on the input channel (in_valid, in_stall,
// name_byte, last). A zero byte ends the name; bytes after it up to the word
// marked last are ignored. For each name one verdict word leaves on the
// output channel (out_valid, out_stall, printable): 1 when the name is
// non-empty, shorter than MAX_NAME bytes, free of control characters and
// well-formed utf8, else 0.
// Throughput: one byte per cycle unless a last word waits on a held verdict.
// Path: a last word passes the input register, then, once the result slot
// is free, the result register, which raises out_valid with its verdict.
// While a verdict waits under out_stall, bytes that give no verdict still
// flow; in_stall rises only when a further last word is held behind it.
// A stalled verdict holds its value until taken.
// Reset (rst, synchronous) empties both registers and clears the name state.
`timescale 1ns / 1ps

module utf8_name_validator_top
  import utf8nv_pkg::*;
#(
  parameter int MAX_NAME = 33
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] name_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       printable
);

  logic  s1_valid;
  item_t s1_item;
  logic  consume;

  // input register
  utf8nv_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .name_byte (name_byte),
    .last      (last),
    .consume   (consume),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  // checking stage and verdict register
  utf8nv_core #(
    .MAX_NAME (MAX_NAME)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_stall (out_stall),
    .consume   (consume),
    .out_valid (out_valid),
    .printable (printable)
  );

endmodule

FILE: src/utf8nv_checker.sv
// port checker for the utf8 name validator, bound to the top level
`timescale 1ns / 1ps
`include "utf8_name_validator_top_macros.svh"

module utf8nv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       printable
);

  // a verdict under stall stays put
  `UNV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(printable))

  // the input side is held back only by a waiting verdict
  `UNV_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

  // reset leaves both channels empty and open
  `UNV_ASSERT_IMPL(a_reset_clear, $past(rst), !out_valid && !in_stall)

endmodule

bind utf8_name_validator_top utf8nv_checker u_chk (.*);
